// File: hw/rtl/lrrs_pkg.sv
// Shared constants, codes and handshake types for the linear recurrence
// range-sum block. No dependencies.
package lrrs_pkg;

    localparam int MAX_ORDER  = 15;
    localparam int WORD_BITS  = 32;
    localparam int INDEX_BITS = 60;
    localparam int ORDER_BITS = 4;
    localparam int SEL_BITS   = 2;
    localparam int ADDR_BITS  = SEL_BITS + 2 * ORDER_BITS;
    localparam int MEM_DEPTH  = 1 << ADDR_BITS;
    localparam int CNT_BITS   = $clog2(WORD_BITS);

    localparam logic [1:0] OP_LOAD_COEF = 2'd0;
    localparam logic [1:0] OP_LOAD_INIT = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    localparam logic [3:0] CFG_ORDER   = 4'd0;
    localparam logic [3:0] CFG_MODULUS = 4'd1;

    localparam logic [SEL_BITS-1:0] MAT_ACC = 2'd0;
    localparam logic [SEL_BITS-1:0] MAT_POW = 2'd1;
    localparam logic [SEL_BITS-1:0] MAT_SCR = 2'd2;

    typedef struct packed {
        logic                 start;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
    } mm_req_t;

    typedef struct packed {
        logic                 done;
        logic [WORD_BITS-1:0] result;
    } mm_resp_t;

endpackage

// File: hw/rtl/lrrs_mulmod.sv
// Bit-serial modular multiplier: a * b mod p, one bit of a per cycle.
// a may be any word; b must be below p. Uses lrrs_pkg.
module lrrs_mulmod import lrrs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [WORD_BITS:0]   p,
    input  mm_req_t              req,
    output mm_resp_t             resp
);

    logic                 busy_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic                 done_reg;
    logic [WORD_BITS:0]   dbl;
    logic [WORD_BITS:0]   dbl_red;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   sum_red;
    logic [WORD_BITS-1:0] acc_next;

    always_comb begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= p) ? dbl - p : dbl;
        sum     = {1'b0, dbl_red[WORD_BITS-1:0]} + {1'b0, b_reg};
        sum_red = (sum >= p) ? sum - p : sum;
        acc_next = a_reg[WORD_BITS-1] ? sum_red[WORD_BITS-1:0] : dbl_red[WORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                a_reg   <= {a_reg[WORD_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(WORD_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign resp.done   = done_reg;
    assign resp.result = acc_reg;

endmodule

// File: hw/rtl/linear_recurrence_range_sum.sv
// Range sum of an order-k linear recurrence mod p, by matrix power.
// A query with n > k per prefix sum runs about 2*log2(n) matrix products of
// (k+1)^3 multiply-accumulates on the bit-serial modular multiplier and the single
// matrix memory. Reversed ranges pass through S_QSTART and S_OUT to the output.
// Reset returns control to idle, drops the output valid and sets order and modulus
// to 1; the coefficient, initial-term and matrix stores are undefined until written.
module linear_recurrence_range_sum import lrrs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // slot[3:0], value[35:4], first_index[95:36],
                                    // last_index[155:96], zero pad
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // range_sum
    output logic [0:0]   m_tuser,   // status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_QSTART, S_PSTART, S_TOT_CHK, S_TOT_MUL, S_TOT_WAIT, S_TOT_END,
        S_INIT_MUL, S_INIT_WAIT, S_INIT_ACC, S_EXP_CHK, S_EXP_SHIFT,
        S_MM_RD, S_MM_MUL, S_MM_WAIT, S_MM_WR, S_CP_RD, S_CP_WR,
        S_FN_RD, S_FN_MUL, S_FN_WAIT, S_PDONE, S_OUT
    } state_t;

    state_t                  state_reg;
    logic [ORDER_BITS-1:0]   order_reg;
    logic [WORD_BITS-1:0]    modulus_reg;
    logic [WORD_BITS-1:0]    coef_reg [0:MAX_ORDER];
    logic [WORD_BITS-1:0]    init_reg [0:MAX_ORDER];
    logic [INDEX_BITS-1:0]   first_reg;
    logic [INDEX_BITS-1:0]   last_reg;
    logic [INDEX_BITS-1:0]   n_reg;
    logic [INDEX_BITS-1:0]   e_reg;
    logic                    phase_reg;
    logic                    mm_sel_reg;
    logic [WORD_BITS-1:0]    hi_reg;
    logic [WORD_BITS-1:0]    tot_reg;
    logic [WORD_BITS-1:0]    sum_reg;
    logic [WORD_BITS-1:0]    res_reg;
    logic                    status_reg;
    logic [ORDER_BITS-1:0]   i_reg;
    logic [ORDER_BITS-1:0]   j_reg;
    logic [ORDER_BITS-1:0]   t_reg;
    logic [ORDER_BITS-1:0]   lim_reg;
    logic                    m_tvalid_reg;
    logic [WORD_BITS-1:0]    m_data_reg;
    logic                    m_status_reg;

    logic [WORD_BITS-1:0]    mem [0:MEM_DEPTH-1];
    logic [WORD_BITS-1:0]    rd_a_reg;
    logic [WORD_BITS-1:0]    rd_b_reg;
    logic [ADDR_BITS-1:0]    addr_a;
    logic [ADDR_BITS-1:0]    addr_b;
    logic                    we;
    logic [ADDR_BITS-1:0]    waddr;
    logic [WORD_BITS-1:0]    wdata;

    logic [WORD_BITS:0]      p;
    logic [WORD_BITS-1:0]    one;
    logic [ORDER_BITS-1:0]   k;
    logic [WORD_BITS:0]      add_s;
    logic [WORD_BITS-1:0]    add_red;
    logic [WORD_BITS-1:0]    init_raw;
    logic [WORD_BITS:0]      diff;
    logic                    last_ij;
    logic                    n_small;
    logic [SEL_BITS-1:0]     lhs_sel;
    logic [SEL_BITS-1:0]     dst_sel;
    mm_req_t                 mreq;
    mm_resp_t                mresp;

    assign p   = (modulus_reg == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, modulus_reg};
    assign one = (modulus_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
    assign k   = (order_reg == '0) ? ORDER_BITS'(1) : order_reg;
    assign lhs_sel = mm_sel_reg ? MAT_POW : MAT_ACC;
    assign dst_sel = mm_sel_reg ? MAT_POW : MAT_ACC;
    assign last_ij = (i_reg == k) && (j_reg == k);
    assign n_small = n_reg <= INDEX_BITS'(k);

    assign add_s   = {1'b0, sum_reg} + {1'b0, mresp.result};
    assign add_red = (add_s >= p) ? WORD_BITS'(add_s - p) : add_s[WORD_BITS-1:0];
    assign diff    = (hi_reg >= sum_reg) ? {1'b0, hi_reg} - {1'b0, sum_reg}
                                         : {1'b0, hi_reg} + (p - {1'b0, sum_reg});

    always_comb begin
        if (i_reg == '0)
            init_raw = (j_reg == '0) ? WORD_BITS'(1) : coef_reg[j_reg];
        else if (i_reg == ORDER_BITS'(1))
            init_raw = (j_reg == '0) ? '0 : coef_reg[j_reg];
        else
            init_raw = ({1'b0, j_reg} + 1'b1 == {1'b0, i_reg}) ? WORD_BITS'(1) : '0;
    end

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        we     = 1'b0;
        waddr  = '0;
        wdata  = '0;
        mreq.start = 1'b0;
        mreq.a     = '0;
        mreq.b     = one;
        unique case (state_reg)
            S_TOT_MUL: begin
                mreq.start = 1'b1;
                mreq.a     = init_reg[i_reg];
            end
            S_INIT_MUL: begin
                mreq.start = 1'b1;
                mreq.a     = init_raw;
            end
            S_INIT_WAIT: begin
                we    = mresp.done;
                waddr = {MAT_POW, i_reg, j_reg};
                wdata = mresp.result;
            end
            S_INIT_ACC: begin
                we    = 1'b1;
                waddr = {MAT_ACC, i_reg, j_reg};
                wdata = (i_reg == j_reg) ? one : '0;
            end
            S_MM_RD: begin
                addr_a = {lhs_sel, i_reg, t_reg};
                addr_b = {MAT_POW, t_reg, j_reg};
            end
            S_MM_MUL: begin
                mreq.start = 1'b1;
                mreq.a     = rd_a_reg;
                mreq.b     = rd_b_reg;
            end
            S_MM_WR: begin
                we    = 1'b1;
                waddr = {MAT_SCR, i_reg, j_reg};
                wdata = sum_reg;
            end
            S_CP_RD: addr_a = {MAT_SCR, i_reg, j_reg};
            S_CP_WR: begin
                we    = 1'b1;
                waddr = {dst_sel, i_reg, j_reg};
                wdata = rd_a_reg;
            end
            S_FN_RD: addr_b = {MAT_ACC, ORDER_BITS'(0), i_reg};
            S_FN_MUL: begin
                mreq.start = 1'b1;
                mreq.a     = (i_reg == '0) ? tot_reg : init_reg[k - i_reg + 1'b1];
                mreq.b     = rd_b_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we)
            mem[waddr] <= wdata;
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    lrrs_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .p       (p),
        .req     (mreq),
        .resp    (mresp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            order_reg    <= ORDER_BITS'(1);
            modulus_reg  <= WORD_BITS'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_ORDER)
                    order_reg <= cfg_data[ORDER_BITS-1:0];
                else if (cfg_index == CFG_MODULUS)
                    modulus_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        case (s_tuser)
                            OP_LOAD_COEF: if (s_tdata[3:0] != '0)
                                coef_reg[s_tdata[3:0]] <= s_tdata[35:4];
                            OP_LOAD_INIT: if (s_tdata[3:0] != '0)
                                init_reg[s_tdata[3:0]] <= s_tdata[35:4];
                            OP_QUERY: begin
                                first_reg <= s_tdata[95:36];
                                last_reg  <= s_tdata[155:96];
                                state_reg <= S_QSTART;
                            end
                            default: ;
                        endcase
                    end
                end
                S_QSTART: begin
                    if (first_reg > last_reg) begin
                        res_reg    <= '0;
                        status_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end else begin
                        status_reg <= 1'b0;
                        n_reg      <= last_reg;
                        phase_reg  <= 1'b0;
                        state_reg  <= S_PSTART;
                    end
                end
                S_PSTART: begin
                    lim_reg   <= n_small ? n_reg[ORDER_BITS-1:0] : k;
                    i_reg     <= ORDER_BITS'(1);
                    sum_reg   <= '0;
                    state_reg <= S_TOT_CHK;
                end
                S_TOT_CHK: state_reg <= (lim_reg == '0) ? S_TOT_END : S_TOT_MUL;
                S_TOT_MUL: state_reg <= S_TOT_WAIT;
                S_TOT_WAIT: begin
                    if (mresp.done) begin
                        sum_reg <= add_red;
                        if (i_reg == lim_reg) begin
                            state_reg <= S_TOT_END;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_TOT_MUL;
                        end
                    end
                end
                S_TOT_END: begin
                    if (n_small) begin
                        state_reg <= S_PDONE;
                    end else begin
                        tot_reg   <= sum_reg;
                        e_reg     <= n_reg - INDEX_BITS'(k);
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= S_INIT_MUL;
                    end
                end
                S_INIT_MUL: state_reg <= S_INIT_WAIT;
                S_INIT_WAIT: if (mresp.done) state_reg <= S_INIT_ACC;
                S_INIT_ACC: begin
                    if (last_ij) begin
                        state_reg <= S_EXP_CHK;
                    end else begin
                        state_reg <= S_INIT_MUL;
                        if (j_reg == k) begin
                            j_reg <= '0;
                            i_reg <= i_reg + 1'b1;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                S_EXP_CHK: begin
                    i_reg   <= '0;
                    j_reg   <= '0;
                    t_reg   <= '0;
                    sum_reg <= '0;
                    if (e_reg == '0) begin
                        state_reg <= S_FN_RD;
                    end else if (e_reg[0]) begin
                        mm_sel_reg <= 1'b0;
                        state_reg  <= S_MM_RD;
                    end else begin
                        state_reg <= S_EXP_SHIFT;
                    end
                end
                S_EXP_SHIFT: begin
                    e_reg   <= e_reg >> 1;
                    i_reg   <= '0;
                    j_reg   <= '0;
                    t_reg   <= '0;
                    sum_reg <= '0;
                    if (e_reg[INDEX_BITS-1:1] != '0) begin
                        mm_sel_reg <= 1'b1;
                        state_reg  <= S_MM_RD;
                    end else begin
                        state_reg <= S_EXP_CHK;
                    end
                end
                S_MM_RD:  state_reg <= S_MM_MUL;
                S_MM_MUL: state_reg <= S_MM_WAIT;
                S_MM_WAIT: begin
                    if (mresp.done) begin
                        sum_reg <= add_red;
                        if (t_reg == k) begin
                            state_reg <= S_MM_WR;
                        end else begin
                            t_reg     <= t_reg + 1'b1;
                            state_reg <= S_MM_RD;
                        end
                    end
                end
                S_MM_WR: begin
                    sum_reg <= '0;
                    t_reg   <= '0;
                    if (last_ij) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= S_CP_RD;
                    end else begin
                        state_reg <= S_MM_RD;
                        if (j_reg == k) begin
                            j_reg <= '0;
                            i_reg <= i_reg + 1'b1;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                S_CP_RD: state_reg <= S_CP_WR;
                S_CP_WR: begin
                    if (last_ij) begin
                        state_reg <= mm_sel_reg ? S_EXP_CHK : S_EXP_SHIFT;
                    end else begin
                        state_reg <= S_CP_RD;
                        if (j_reg == k) begin
                            j_reg <= '0;
                            i_reg <= i_reg + 1'b1;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                S_FN_RD:  state_reg <= S_FN_MUL;
                S_FN_MUL: state_reg <= S_FN_WAIT;
                S_FN_WAIT: begin
                    if (mresp.done) begin
                        sum_reg <= add_red;
                        if (i_reg == k) begin
                            state_reg <= S_PDONE;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_FN_RD;
                        end
                    end
                end
                S_PDONE: begin
                    if (phase_reg) begin
                        res_reg   <= diff[WORD_BITS-1:0];
                        state_reg <= S_OUT;
                    end else begin
                        hi_reg <= sum_reg;
                        if (first_reg == '0) begin
                            res_reg   <= sum_reg;
                            state_reg <= S_OUT;
                        end else begin
                            n_reg     <= first_reg - 1'b1;
                            phase_reg <= 1'b1;
                            state_reg <= S_PSTART;
                        end
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= res_reg;
                        m_status_reg <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_status_reg;

endmodule

// File: hw/rtl/lrrs_checker.sv
// Port-level checks for linear_recurrence_range_sum, attached by bind.
// Uses only the top-level ports and lrrs_pkg.
module lrrs_checker import lrrs_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [159:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic [0:0]   m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [3:0]   cfg_index,
    input logic [31:0]  cfg_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("reversed range with nonzero sum");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_QUERY |=> !s_tready)
        else $error("input ready right after a query");

endmodule

bind linear_recurrence_range_sum lrrs_checker u_lrrs_checker (.*);

// File: tb/sv/linear_recurrence_range_sum_test.sv
// Self-checking testbench for linear_recurrence_range_sum: drives table loads, range queries
// and register writes, and checks each result word against a matrix-power predictor in a scoreboard.
// Depends on lrrs_pkg and the linear_recurrence_range_sum RTL.
`timescale 1ns / 1ps

module linear_recurrence_range_sum_test;
    import lrrs_pkg::*;

    localparam int WATCHDOG_CYCLES = 1500000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef bit [INDEX_BITS-1:0] index_t;
    typedef bit [WORD_BITS-1:0]  word_t;

    typedef struct {
        word_t sum;
        bit    status;
    } range_result_t;

    class lrrs_scoreboard;
        int unsigned       errors;
        bit [3:0]          order_reg;
        word_t             modulus_reg;
        word_t             coef_tbl[16];
        word_t             term_tbl[16];
        longint unsigned   pw[16][16];
        longint unsigned   ac[16][16];
        longint unsigned   tmp[16][16];
        range_result_t     sums_due[$];

        function new();
            errors      = 0;
            order_reg   = 4'd1;
            modulus_reg = 32'd1;
        endfunction

        function int pending();
            return sums_due.size();
        endfunction

        function void write_reg(bit [3:0] idx, word_t data);
            if (idx == CFG_ORDER) order_reg = data[3:0];
            else if (idx == CFG_MODULUS) modulus_reg = data;
        endfunction

        // tmp = lhs * pw, lhs is ac or pw; result copied back into lhs
        function void mat_mul(bit into_acc, int d, longint unsigned p);
            longint unsigned s, l;
            for (int i = 0; i < d; i++)
                for (int j = 0; j < d; j++) begin
                    s = 0;
                    for (int t = 0; t < d; t++) begin
                        l = into_acc ? ac[i][t] : pw[i][t];
                        s = (s + (l * pw[t][j]) % p) % p;
                    end
                    tmp[i][j] = s;
                end
            for (int i = 0; i < d; i++)
                for (int j = 0; j < d; j++) begin
                    if (into_acc) ac[i][j] = tmp[i][j];
                    else pw[i][j] = tmp[i][j];
                end
        endfunction

        function longint unsigned prefix_sum(longint unsigned n, int k, longint unsigned p);
            longint unsigned total, res, e;
            total = 0;
            for (int i = 1; i <= k; i++)
                if (i <= n) total = (total + term_tbl[i] % p) % p;
            if (n <= k) return total;
            for (int i = 0; i < 16; i++)
                for (int j = 0; j < 16; j++) begin
                    pw[i][j] = 0;
                    ac[i][j] = (i == j) ? 1 % p : 0;
                end
            pw[0][0] = 1 % p;
            for (int i = 1; i <= k; i++) begin
                pw[0][i] = coef_tbl[i] % p;
                pw[1][i] = coef_tbl[i] % p;
            end
            for (int i = 2; i <= k; i++) pw[i][i-1] = 1 % p;
            e = n - k;
            while (e != 0) begin
                if (e[0]) mat_mul(1'b1, k + 1, p);
                e = e >> 1;
                if (e != 0) mat_mul(1'b0, k + 1, p);
            end
            res = (total * ac[0][0]) % p;
            for (int i = 1; i <= k; i++)
                res = (res + ((term_tbl[k+1-i] % p) * ac[0][i]) % p) % p;
            return res;
        endfunction

        function void note_input(bit [1:0] op, bit [3:0] slot, word_t value,
                                 index_t first, index_t last);
            longint unsigned p, hi, lo;
            int k;
            range_result_t r;
            case (op)
                OP_LOAD_COEF: if (slot != 0) coef_tbl[slot] = value;
                OP_LOAD_INIT: if (slot != 0) term_tbl[slot] = value;
                OP_QUERY: begin
                    if (first > last) begin
                        r.sum = 0;
                        r.status = 1'b1;
                    end else begin
                        p = (modulus_reg == 0) ? 64'h1_0000_0000 : modulus_reg;
                        k = (order_reg == 0) ? 1 : order_reg;
                        hi = prefix_sum(last, k, p);
                        lo = (first == 0) ? 0 : prefix_sum(first - 1, k, p);
                        r.sum = word_t'((hi >= lo) ? hi - lo : hi + (p - lo));
                        r.status = 1'b0;
                    end
                    sums_due.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(word_t sum, bit status);
            range_result_t r;
            if (sums_due.size() == 0) begin
                $display("%0t: unexpected word sum=%h status=%b", $time, sum, status);
                errors++;
                return;
            end
            r = sums_due.pop_front();
            if (r.sum !== sum) begin
                $display("%0t: range_sum expected %h actual %h", $time, r.sum, sum);
                errors++;
            end
            if (r.status !== status) begin
                $display("%0t: status expected %b actual %b", $time, r.status, status);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;   // slot, value, first_index, last_index, zero pad
    logic [1:0]   s_tuser;   // opcode
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;   // range_sum
    logic [0:0]   m_tuser;   // status
    logic         cfg_valid;
    logic         cfg_ready;
    logic [3:0]   cfg_index;
    logic [31:0]  cfg_data;

    lrrs_scoreboard sb = new();
    bit             no_idle;
    int             quiet_cycles = 0;

    linear_recurrence_range_sum u_dut (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 22);
    end

    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(bit [1:0] op, bit [3:0] slot, word_t value,
                             index_t first, index_t last);
        if (!no_idle && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, last, first, value, slot};
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        sb.note_input(op, slot, value, first, last);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(bit [3:0] idx, word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever begin
            @(negedge aclk);
            if (cfg_ready) break;
        end
        sb.write_reg(idx, data);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_phase(bit [3:0] ord, word_t modulus);
        drain();
        write_reg(CFG_ORDER, {28'b0, ord});
        write_reg(CFG_MODULUS, modulus);
    endtask

    task automatic query(index_t first, index_t last);
        send_word(OP_QUERY, 4'($urandom), $urandom, first, last);
    endtask

    task automatic random_query(bit [3:0] ord);
        index_t a, b;
        int r;
        r = $urandom_range(99);
        if (r < 15) begin
            a = index_t'({$urandom, $urandom});
            b = index_t'({$urandom, $urandom});
            if (a == b) a = a + 1;
            if (a > b) query(a, b);
            else query(b, a);
        end else if (r < 20 && ord == 1) begin
            b = '1 - $urandom_range(0, 100);
            query(b - $urandom_range(0, 100), b);
        end else begin
            a = $urandom_range(0, 40);
            query(a, a + $urandom_range(0, 30));
        end
    endtask

    bit [3:0] orders[6]  = '{4'd2, 4'd1, 4'd3, 4'd0, 4'd2, 4'd1};
    word_t    moduli[6]  = '{32'd1000000000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0};

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_LOAD_COEF;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ORDER;
        cfg_data  <= '0;
        no_idle   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(CFG_ORDER, 32'd1);
        write_reg(CFG_MODULUS, 32'd1000000000);
        for (int i = 1; i <= 15; i++) begin
            send_word(OP_LOAD_COEF, 4'(i), (i == 1) ? 32'd0 : $urandom, '0, '0);
            send_word(OP_LOAD_INIT, 4'(i), (i == 15) ? 32'hFFFF_FFFF : $urandom, '0, '0);
        end

        send_word(OP_LOAD_COEF, 4'd0, 32'hFFFF_FFFF, '1, '1);
        send_word(OP_UNUSED, 4'hF, 32'hFFFF_FFFF, '1, '1);
        send_word(OP_LOAD_COEF, 4'd1, 32'hFFFF_FFFF, '0, '0);
        query(0, 0);
        query(0, 1);
        query(1, 1);
        query(3, 2);
        query('1, 1);
        query(5, 0);
        query(1, '1);
        query('1, '1);
        query(0, 100);

        set_phase(4'd15, 32'd0);
        query(1, 16);
        query(0, 15);
        set_phase(4'd5, 32'hFFFF_FFFF);
        query(2, 9);

        for (int ph = 0; ph < 6; ph++) begin
            set_phase(orders[ph], (ph == 3 || ph == 5) ? $urandom : moduli[ph]);
            if (ph == 5) write_reg(4'hF, $urandom);
            no_idle = (ph == 1);
            for (int n = 0; n < 10; n++) begin
                if (n == 5 && ph == 2) drain();
                case ($urandom_range(9))
                    0, 1: send_word(OP_LOAD_COEF, 4'($urandom_range(0, 15)), $urandom,
                                    index_t'({$urandom, $urandom}),
                                    index_t'({$urandom, $urandom}));
                    2:    send_word(OP_LOAD_INIT, 4'($urandom_range(0, 15)), $urandom,
                                    index_t'({$urandom, $urandom}),
                                    index_t'({$urandom, $urandom}));
                    3:    if ($urandom_range(3) == 0)
                              send_word(OP_UNUSED, 4'($urandom), $urandom,
                                        index_t'({$urandom, $urandom}),
                                        index_t'({$urandom, $urandom}));
                          else random_query(orders[ph]);
                    default: random_query(orders[ph] == 0 ? 4'd1 : orders[ph]);
                endcase
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/lrrs_pkg.sv
hw/rtl/lrrs_mulmod.sv
hw/rtl/linear_recurrence_range_sum.sv
hw/rtl/lrrs_checker.sv
tb/sv/linear_recurrence_range_sum_test.sv
